FILE: hdl/button_gesture_classifier_defines.svh
// Assertion macros shared by the button gesture classifier RTL.
`ifndef BUTTON_GESTURE_CLASSIFIER_DEFINES_SVH
`define BUTTON_GESTURE_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS
// Check that cons holds in the same cycle whenever ante holds.
`define BGC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Check that cons holds in the cycle after ante holds.
`define BGC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define BGC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define BGC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/bgc_pkg.sv
// Types and constants for the button gesture classifier.
package bgc_pkg;

  // Gesture codes; the none code marks that no hold or tap was reported since reset or the last press
  typedef enum logic [3:0] {
    GEST_PRESSED    = 4'd0,
    GEST_RELEASED   = 4'd1,
    GEST_HOLD       = 4'd2,
    GEST_LONG_HOLD  = 4'd3,
    GEST_VLONG_HOLD = 4'd4,
    GEST_SINGLE_TAP = 4'd5,
    GEST_LONG_TAP   = 4'd6,
    GEST_VLONG_TAP  = 4'd7,
    GEST_NONE       = 4'd8
  } gesture_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_SINGLE_TAP  = 3'd0,
    CFG_LONG_TAP    = 3'd1,
    CFG_VLONG_TAP   = 3'd2,
    CFG_HOLD        = 3'd3,
    CFG_LONG_HOLD   = 3'd4,
    CFG_VLONG_HOLD  = 3'd5
  } cfg_idx_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Threshold reset values in milliseconds
  localparam logic [CFG_DATA_W-1:0] RST_SINGLE_TAP = 16'd50;
  localparam logic [CFG_DATA_W-1:0] RST_LONG_TAP   = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] RST_VLONG_TAP  = 16'd3000;
  localparam logic [CFG_DATA_W-1:0] RST_HOLD       = 16'd500;
  localparam logic [CFG_DATA_W-1:0] RST_LONG_HOLD  = 16'd2000;
  localparam logic [CFG_DATA_W-1:0] RST_VLONG_HOLD = 16'd5000;

  // Result queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = QAW + 1;

  typedef struct packed {
    logic        is_pressed;
    logic [31:0] now_ms;
  } bgc_in_t;

  typedef struct packed {
    logic [2:0] gesture;
    logic       last_of_run;
  } bgc_out_t;

endpackage

FILE: hdl/button_gesture_classifier.sv
// A report's first result is shown the cycle after acceptance if the queue was empty.
// Throughput: one report per cycle while the four-entry result queue has two free slots;
//   it drains one result per unstalled cycle, so taps on release limit that to 1/2.
// State (level, change time, last gesture) is updated at the accepting clock edge.
// Reset (asynchronous, active low): released, change time zero, no gesture,
//   thresholds at their defaults, result queue empty.
`include "button_gesture_classifier_defines.svh"

module button_gesture_classifier import bgc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  bgc_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output bgc_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Threshold registers
  logic [CFG_DATA_W-1:0] single_tap_q, long_tap_q, vlong_tap_q;
  logic [CFG_DATA_W-1:0] hold_q, long_hold_q, vlong_hold_q;

  // Classifier state
  logic        prev_pressed_q, prev_pressed_d;
  logic [31:0] change_q, change_d;
  gesture_e    last_g_q, last_g_d;

  // Result queue
  bgc_out_t         queue_q [QDEPTH];
  logic [QAW-1:0]   wr_q, rd_q;
  logic [QCW-1:0]   cnt_q, cnt_d;

  logic        in_acc, pop;
  logic [31:0] elapsed;
  logic [1:0]  n_res;
  gesture_e    g0, g1;
  bgc_out_t    item0, item1;

  assign in_stall_o  = (cnt_q > QCW'(QDEPTH - 2));
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = queue_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;

  // Wrapping elapsed time since the last change
  assign elapsed = in_data_i.now_ms - change_q;

  // Write thresholds; ignore indexes past the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      single_tap_q <= RST_SINGLE_TAP;
      long_tap_q   <= RST_LONG_TAP;
      vlong_tap_q  <= RST_VLONG_TAP;
      hold_q       <= RST_HOLD;
      long_hold_q  <= RST_LONG_HOLD;
      vlong_hold_q <= RST_VLONG_HOLD;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SINGLE_TAP: single_tap_q <= cfg_data_i;
        CFG_LONG_TAP:   long_tap_q   <= cfg_data_i;
        CFG_VLONG_TAP:  vlong_tap_q  <= cfg_data_i;
        CFG_HOLD:       hold_q       <= cfg_data_i;
        CFG_LONG_HOLD:  long_hold_q  <= cfg_data_i;
        CFG_VLONG_HOLD: vlong_hold_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Classify the report and pick the next state
  always_comb begin
    prev_pressed_d = prev_pressed_q;
    change_d       = change_q;
    last_g_d       = last_g_q;
    n_res          = 2'd0;
    g0             = GEST_PRESSED;
    g1             = GEST_NONE;
    if (in_data_i.is_pressed) begin
      prev_pressed_d = 1'b1;
      if (!prev_pressed_q) begin
        change_d = in_data_i.now_ms;
        last_g_d = GEST_NONE;
        g0       = GEST_PRESSED;
        n_res    = 2'd1;
      end else if (elapsed > {16'd0, vlong_hold_q} && last_g_q != GEST_VLONG_HOLD) begin
        last_g_d = GEST_VLONG_HOLD;
        g0       = GEST_VLONG_HOLD;
        n_res    = 2'd1;
      end else if (elapsed > {16'd0, long_hold_q} && elapsed < {16'd0, vlong_hold_q} &&
                   last_g_q != GEST_LONG_HOLD) begin
        last_g_d = GEST_LONG_HOLD;
        g0       = GEST_LONG_HOLD;
        n_res    = 2'd1;
      end else if (elapsed > {16'd0, hold_q} && elapsed < {16'd0, long_hold_q} &&
                   last_g_q != GEST_HOLD) begin
        last_g_d = GEST_HOLD;
        g0       = GEST_HOLD;
        n_res    = 2'd1;
      end
    end else begin
      prev_pressed_d = 1'b0;
      change_d       = in_data_i.now_ms;
      g0             = GEST_RELEASED;
      n_res          = 2'd1;
      if (elapsed > {16'd0, vlong_tap_q} && last_g_q != GEST_VLONG_TAP) begin
        last_g_d = GEST_VLONG_TAP;
        g1       = GEST_VLONG_TAP;
        n_res    = 2'd2;
      end else if (elapsed > {16'd0, long_tap_q} && last_g_q != GEST_LONG_TAP) begin
        last_g_d = GEST_LONG_TAP;
        g1       = GEST_LONG_TAP;
        n_res    = 2'd2;
      end else if (elapsed > {16'd0, single_tap_q} && last_g_q != GEST_SINGLE_TAP) begin
        last_g_d = GEST_SINGLE_TAP;
        g1       = GEST_SINGLE_TAP;
        n_res    = 2'd2;
      end
    end
  end

  // Build the result transactions
  always_comb begin
    item0.gesture     = g0[2:0];
    item0.last_of_run = (n_res == 2'd1);
    item1.gesture     = g1[2:0];
    item1.last_of_run = 1'b1;
  end

  // Update state on an accepted report
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pressed_q <= 1'b0;
      change_q       <= '0;
      last_g_q       <= GEST_NONE;
    end else if (in_acc) begin
      prev_pressed_q <= prev_pressed_d;
      change_q       <= change_d;
      last_g_q       <= last_g_d;
    end
  end

  // Advance queue pointers and fill count
  assign cnt_d = cnt_q + (in_acc ? QCW'(n_res) : QCW'(0)) - QCW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (in_acc) begin
        wr_q <= wr_q + QAW'(n_res);
      end
      if (pop) begin
        rd_q <= rd_q + QAW'(1);
      end
    end
  end

  // Store result transactions
  always_ff @(posedge clk_i) begin
    if (in_acc && n_res != 2'd0) begin
      queue_q[wr_q] <= item0;
    end
    if (in_acc && n_res == 2'd2) begin
      queue_q[wr_q + QAW'(1)] <= item1;
    end
  end

  `BGC_ASSERT_IMPLY(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= QCW'(QDEPTH))
  `BGC_ASSERT_NEXT(a_fresh_press, clk_i, rst_ni,
    in_acc && in_data_i.is_pressed && !prev_pressed_q,
    prev_pressed_q && last_g_q == GEST_NONE && cnt_q == $past(cnt_d))
  `BGC_ASSERT_NEXT(a_release_pushes, clk_i, rst_ni,
    in_acc && !in_data_i.is_pressed && !pop, cnt_q > $past(cnt_q))
  `BGC_ASSERT_NEXT(a_pop_only, clk_i, rst_ni,
    pop && !in_acc, cnt_q == $past(cnt_q) - QCW'(1))

endmodule

FILE: bench/tb_button_gesture_classifier.sv
// Self-checking testbench for the button gesture classifier, with a gesture predictor.
`timescale 1ns / 100ps

import bgc_pkg::*;

// Track the button state and hold the gestures still owed by the block
class gesture_scoreboard;
  logic [CFG_DATA_W-1:0] thr [6];
  logic                  was_pressed;
  logic [31:0]           change_time;
  gesture_e              last_gesture;
  bgc_out_t              expected_q [$];
  int                    errors;

  function new();
    thr[CFG_SINGLE_TAP] = RST_SINGLE_TAP;
    thr[CFG_LONG_TAP]   = RST_LONG_TAP;
    thr[CFG_VLONG_TAP]  = RST_VLONG_TAP;
    thr[CFG_HOLD]       = RST_HOLD;
    thr[CFG_LONG_HOLD]  = RST_LONG_HOLD;
    thr[CFG_VLONG_HOLD] = RST_VLONG_HOLD;
    was_pressed  = 1'b0;
    change_time  = '0;
    last_gesture = GEST_NONE;
    errors       = 0;
  endfunction

  // Ignore writes to indexes past the last threshold
  function void write_threshold(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    if (idx <= CFG_VLONG_HOLD) begin
      thr[idx] = val;
    end
  endfunction

  // Classify one accepted report and queue the gestures it causes
  function void note_report(input bgc_in_t rep);
    logic [31:0] elapsed;
    gesture_e    found [$];
    bgc_out_t    item;
    elapsed = rep.now_ms - change_time;
    if (rep.is_pressed) begin
      if (!was_pressed) begin
        change_time  = rep.now_ms;
        last_gesture = GEST_NONE;
        found.push_back(GEST_PRESSED);
      end else if (elapsed > thr[CFG_VLONG_HOLD] && last_gesture != GEST_VLONG_HOLD) begin
        last_gesture = GEST_VLONG_HOLD;
        found.push_back(GEST_VLONG_HOLD);
      end else if (elapsed > thr[CFG_LONG_HOLD] && elapsed < thr[CFG_VLONG_HOLD] &&
                   last_gesture != GEST_LONG_HOLD) begin
        last_gesture = GEST_LONG_HOLD;
        found.push_back(GEST_LONG_HOLD);
      end else if (elapsed > thr[CFG_HOLD] && elapsed < thr[CFG_LONG_HOLD] &&
                   last_gesture != GEST_HOLD) begin
        last_gesture = GEST_HOLD;
        found.push_back(GEST_HOLD);
      end
    end else begin
      found.push_back(GEST_RELEASED);
      if (elapsed > thr[CFG_VLONG_TAP] && last_gesture != GEST_VLONG_TAP) begin
        last_gesture = GEST_VLONG_TAP;
        found.push_back(GEST_VLONG_TAP);
      end else if (elapsed > thr[CFG_LONG_TAP] && last_gesture != GEST_LONG_TAP) begin
        last_gesture = GEST_LONG_TAP;
        found.push_back(GEST_LONG_TAP);
      end else if (elapsed > thr[CFG_SINGLE_TAP] && last_gesture != GEST_SINGLE_TAP) begin
        last_gesture = GEST_SINGLE_TAP;
        found.push_back(GEST_SINGLE_TAP);
      end
      change_time = rep.now_ms;
    end
    was_pressed = rep.is_pressed;
    foreach (found[k]) begin
      item.gesture     = found[k][2:0];
      item.last_of_run = (k == found.size() - 1);
      expected_q.push_back(item);
    end
  endfunction

  // Compare one accepted result with the oldest owed gesture
  function void check_result(input bgc_out_t got);
    bgc_out_t want;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual gesture=%0d last=%0b",
               $time, got.gesture, got.last_of_run);
      return;
    end
    want = expected_q.pop_front();
    if (got.gesture !== want.gesture) begin
      errors++;
      $display("%0t: gesture mismatch, expected %0d, actual %0d",
               $time, want.gesture, got.gesture);
    end
    if (got.last_of_run !== want.last_of_run) begin
      errors++;
      $display("%0t: last_of_run mismatch, expected %0b, actual %0b",
               $time, want.last_of_run, got.last_of_run);
    end
  endfunction
endclass

module tb_button_gesture_classifier;

  localparam int CYCLE_LIMIT    = 500000;
  localparam int DRAIN_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASES         = 8;
  localparam int PHASE_REPORTS  = 200;
  localparam int IDLE_STRETCH   = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_W'(CFG_VLONG_HOLD + 1);

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  bgc_in_t               in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  bgc_out_t              out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  gesture_scoreboard     sb = new();
  logic [CFG_DATA_W-1:0] next_thr [6];
  bit                    idle_on = 1'b1;
  int                    reports_sent = 0;
  int                    rx_hold = 0;
  int                    cycles = 0;

  button_gesture_classifier uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Take results, then, while idle_on is set, stall for a random number of cycles per transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(out_data_o);
        rx_hold = idle_on ? $urandom_range(0, 9) : 0;
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      out_stall_i <= (rx_hold > 0);
    end
  end

  // Send one report after a random gap; return at the accepting edge
  task automatic push_report(input logic pressed, input logic [31:0] now);
    int      gap;
    bgc_in_t rep;
    if (reports_sent % IDLE_STRETCH == 0) begin
      idle_on = ($urandom_range(0, 3) != 0);
    end
    reports_sent++;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rep.is_pressed = pressed;
    rep.now_ms     = now;
    in_valid_i <= 1'b1;
    in_data_i  <= rep;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_report(rep);
  endtask

  // Drop valid and wait until every owed gesture has come out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all thresholds from next_thr, then poke the unused indexes
  task automatic apply_thresholds();
    logic [CFG_DATA_W-1:0] junk;
    for (int i = CFG_SINGLE_TAP; i <= CFG_VLONG_HOLD; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_IDX_W'(i);
      cfg_data_i <= next_thr[i];
      @(posedge clk_i);
      sb.write_threshold(CFG_IDX_W'(i), next_thr[i]);
    end
    for (int i = CFG_IDX_SPARE; i < 2 ** CFG_IDX_W; i++) begin
      junk = CFG_DATA_W'($urandom_range(0, 65535));
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_IDX_W'(i);
      cfg_data_i <= junk;
      @(posedge clk_i);
      sb.write_threshold(CFG_IDX_W'(i), junk);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Pick an elapsed time, mostly at or next to some threshold
  function automatic logic [31:0] pick_elapsed();
    logic [31:0] base;
    base = {16'd0, sb.thr[$urandom_range(0, 5)]};
    case ($urandom_range(0, 7))
      0: return base - 1;
      1: return base;
      2: return base + 1;
      3: return $urandom_range(0, 70000);
      4: return $urandom;
      5: return '0;
      default: return base + $urandom_range(0, 40);
    endcase
  endfunction

  // Press, hold for a rising time, then release
  task automatic run_gesture();
    logic [31:0] held;
    logic [31:0] next_d;
    int          holds;
    push_report(1'b1, sb.change_time + pick_elapsed());
    held  = '0;
    holds = $urandom_range(0, 4);
    repeat (holds) begin
      next_d = pick_elapsed();
      if (next_d < held) begin
        next_d = held + $urandom_range(0, 50);
      end
      held = next_d;
      push_report(1'b1, sb.change_time + held);
    end
    push_report(1'b0, sb.change_time + pick_elapsed());
  endtask

  // Random reports, mostly whole gestures, some noise
  task automatic run_random(input int count);
    int start;
    start = reports_sent;
    while (reports_sent - start < count) begin
      if ($urandom_range(0, 6) == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          push_report(1'($urandom_range(0, 1)), $urandom);
        end else begin
          push_report(1'($urandom_range(0, 1)), sb.change_time + pick_elapsed());
        end
      end else begin
        run_gesture();
      end
    end
  endtask

  // Exercise window bounds, repeats, taps and tick wrap at reset thresholds
  task automatic run_directed();
    push_report(1'b0, 32'd0);            // release while released, no tap
    push_report(1'b1, 32'd100);          // fresh press
    push_report(1'b1, 32'd100);          // no time held
    push_report(1'b1, 32'd600);          // exactly on hold bound
    push_report(1'b1, 32'd601);          // hold
    push_report(1'b1, 32'd700);          // hold already reported
    push_report(1'b1, 32'd2100);         // exactly on long hold bound
    push_report(1'b1, 32'd2101);         // long hold
    push_report(1'b1, 32'd5100);         // exactly on very long hold bound
    push_report(1'b1, 32'd5101);         // very long hold
    push_report(1'b0, 32'd5200);         // very long tap
    push_report(1'b0, 32'd5230);         // short release gap, no tap
    push_report(1'b0, 32'd5300);         // single tap from release to release
    push_report(1'b0, 32'd5400);         // single tap already reported
    push_report(1'b1, 32'd5500);         // fresh press clears the mark
    push_report(1'b0, 32'd5600);         // repeated single tap
    push_report(1'b1, 32'd5700);
    push_report(1'b0, 32'd6750);         // long tap
    push_report(1'b1, 32'hFFFF_FF00);    // press just below the wrap
    push_report(1'b1, 32'h0000_0200);    // hold across the wrap
    push_report(1'b0, 32'h0000_0300);    // long tap across the wrap
    push_report(1'b1, 32'hFFFF_FFFF);
    push_report(1'b0, 32'hFFFF_FFFF);    // instant release
  endtask

  initial begin
    int guard;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random(PHASE_REPORTS);

    // Step through threshold settings, extremes first
    for (int p = 1; p < PHASES; p++) begin
      wait_idle();
      for (int i = 0; i < 6; i++) begin
        case (p)
          1: next_thr[i] = '0;
          2: next_thr[i] = '1;
          3, 5, 7: next_thr[i] = CFG_DATA_W'($urandom_range(0, 300));
          4: next_thr[i] = CFG_DATA_W'($urandom_range(0, 65535));
          default: next_thr[i] = CFG_DATA_W'($urandom_range(0, 3000));
        endcase
      end
      apply_thresholds();
      run_random(PHASE_REPORTS);
    end

    // Drain, then look for stray or missing results
    in_valid_i <= 1'b0;
    guard = 0;
    while (sb.expected_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.expected_q.size() != 0) begin
      sb.errors++;
      $display("%0t: missing results, expected %0d more, actual 0",
               $time, sb.expected_q.size());
    end
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/bgc_pkg.sv
hdl/button_gesture_classifier.sv
bench/tb_button_gesture_classifier.sv
